// File: rtl/core/date_day_difference_macros.svh
// Assertion macros shared by the date difference checker.
// No dependencies; included by datediff_checker.sv.
`ifndef DATE_DAY_DIFFERENCE_MACROS_SVH
`define DATE_DAY_DIFFERENCE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked at every clock edge outside reset.
`define DD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/datediff_pkg.sv
// Types, constants and calendar helpers for the date difference block.
// No dependencies; used by date_day_difference and datediff_checker.
`default_nettype none

package datediff_pkg;

	typedef struct packed {
		logic [4:0]  day_a;
		logic [3:0]  month_a;
		logic [13:0] year_a;
		logic [4:0]  day_b;
		logic [3:0]  month_b;
		logic [13:0] year_b;
	} date_pair_t;

	typedef struct packed {
		logic [21:0] days_apart;
		logic [1:0]  order;
		logic        valid_a;
		logic        valid_b;
		logic        leap_a;
		logic        leap_b;
	} result_t;

	localparam logic [1:0] ORD_EQUAL     = 2'd0;
	localparam logic [1:0] ORD_A_LATER   = 2'd1;
	localparam logic [1:0] ORD_A_EARLIER = 2'd2;

	localparam logic [22:0] DAYS_MAX = 23'd4194303;

	// x / 25 == (x * RECIP_25) >> RECIP_SHIFT for x < 4096
	localparam logic [10:0] RECIP_25    = 11'd1311;
	localparam int          RECIP_SHIFT = 15;

	localparam logic [3:0] MONTH_FEB = 4'd2;

	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			MONTH_FEB:               n = leap ? 5'd29 : 5'd28;
			default:                 n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/date_day_difference.sv
// Gregorian date difference: five-stage pipeline from a date pair to day count.
// Depends on datediff_pkg.
//
// One date pair is taken per clock on start (busy stays low, the pipe never
// stalls). The result appears on result with done high for one cycle once
// the pair has passed input register, reciprocal multiplies for the
// /100 terms, leap and validity decode with the base day number, month offset
// add, then absolute difference and saturation into the output register.
// The receiver must take every result in the cycle it is shown.
`default_nettype none

module date_day_difference (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire datediff_pkg::date_pair_t dates,
	output logic                         done,
	output datediff_pkg::result_t        result
);

	// stage 1: input register
	logic                     valid_s1;
	datediff_pkg::date_pair_t dates_s1;

	// stage 2: products
	logic        valid_s2;
	logic [4:0]  day_s2 [2];
	logic [3:0]  mon_s2 [2];
	logic [13:0] yr_s2 [2];
	logic [22:0] p365_s2 [2];
	logic [11:0] p4_s2 [2];
	logic [22:0] pq_s2 [2];
	logic [22:0] yq_s2 [2];
	logic [1:0]  order_s2;

	// stage 3: decoded
	logic        valid_s3;
	logic [22:0] nbase_s3 [2];
	logic [8:0]  doff_s3 [2];
	logic        leap_s3 [2];
	logic        ok_s3 [2];
	logic [1:0]  order_s3;

	// stage 4: day numbers
	logic        valid_s4;
	logic [22:0] n_s4 [2];
	logic        leap_s4 [2];
	logic        ok_s4 [2];
	logic [1:0]  order_s4;

	// output
	logic                  done_q;
	datediff_pkg::result_t result_q;

	logic [4:0]  day_c [2];
	logic [3:0]  mon_c [2];
	logic [13:0] yr_c [2];
	logic [13:0] p_c [2];
	logic [22:0] key_a;
	logic [22:0] key_b;
	logic [1:0]  order_c;

	logic [7:0]  c100p_c [2];
	logic [7:0]  c100y_c [2];
	logic        div100_c [2];
	logic        leap_c [2];
	logic        ok_c [2];
	logic [22:0] nbase_c [2];
	logic [8:0]  doff_c [2];

	logic [22:0] diff_c;
	logic [21:0] days_c;

	assign busy   = 1'b0;
	assign done   = done_q;
	assign result = result_q;

	always_comb begin
		day_c[0] = dates_s1.day_a;
		mon_c[0] = dates_s1.month_a;
		yr_c[0]  = dates_s1.year_a;
		day_c[1] = dates_s1.day_b;
		mon_c[1] = dates_s1.month_b;
		yr_c[1]  = dates_s1.year_b;
		for (int i = 0; i < 2; i++) begin
			p_c[i] = yr_c[i] - 14'd1;
		end
		key_a = {dates_s1.year_a, dates_s1.month_a, dates_s1.day_a};
		key_b = {dates_s1.year_b, dates_s1.month_b, dates_s1.day_b};
		if (key_a == key_b) begin
			order_c = datediff_pkg::ORD_EQUAL;
		end else if (key_a > key_b) begin
			order_c = datediff_pkg::ORD_A_LATER;
		end else begin
			order_c = datediff_pkg::ORD_A_EARLIER;
		end
	end

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			c100p_c[i]  = pq_s2[i][datediff_pkg::RECIP_SHIFT +: 8];
			c100y_c[i]  = yq_s2[i][datediff_pkg::RECIP_SHIFT +: 8];
			div100_c[i] = (yr_s2[i] == 14'(14'(c100y_c[i]) * 14'd100));
			leap_c[i]   = ((yr_s2[i][1:0] == 2'd0) && !div100_c[i])
				|| (div100_c[i] && (c100y_c[i][1:0] == 2'd0));
			ok_c[i]     = (mon_s2[i] >= 4'd1) && (mon_s2[i] <= 4'd12)
				&& (yr_s2[i] != 14'd0) && (day_s2[i] != 5'd0)
				&& (day_s2[i] <= datediff_pkg::month_len(mon_s2[i], leap_c[i]));
			nbase_c[i]  = p365_s2[i] + 23'(p4_s2[i]) - 23'(c100p_c[i])
				+ 23'(c100p_c[i][7:2]);
			doff_c[i]   = datediff_pkg::days_before(mon_s2[i])
				+ 9'((mon_s2[i] > datediff_pkg::MONTH_FEB) && leap_c[i])
				+ 9'(day_s2[i]);
		end
	end

	always_comb begin
		if (n_s4[0] >= n_s4[1]) begin
			diff_c = n_s4[0] - n_s4[1];
		end else begin
			diff_c = n_s4[1] - n_s4[0];
		end
		if (!(ok_s4[0] && ok_s4[1])) begin
			days_c = 22'd0;
		end else if (diff_c > datediff_pkg::DAYS_MAX) begin
			days_c = datediff_pkg::DAYS_MAX[21:0];
		end else begin
			days_c = diff_c[21:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			done_q   <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			dates_s1 <= dates;
		end
		order_s2 <= order_c;
		order_s3 <= order_s2;
		order_s4 <= order_s3;
		for (int i = 0; i < 2; i++) begin
			day_s2[i]   <= day_c[i];
			mon_s2[i]   <= mon_c[i];
			yr_s2[i]    <= yr_c[i];
			p365_s2[i]  <= 23'(p_c[i]) * 23'd365;
			p4_s2[i]    <= p_c[i][13:2];
			pq_s2[i]    <= 23'(p_c[i][13:2]) * 23'(datediff_pkg::RECIP_25);
			yq_s2[i]    <= 23'(yr_c[i][13:2]) * 23'(datediff_pkg::RECIP_25);
			nbase_s3[i] <= nbase_c[i];
			doff_s3[i]  <= doff_c[i];
			leap_s3[i]  <= leap_c[i];
			ok_s3[i]    <= ok_c[i];
			n_s4[i]     <= nbase_s3[i] + 23'(doff_s3[i]);
			leap_s4[i]  <= leap_s3[i];
			ok_s4[i]    <= ok_s3[i];
		end
		result_q.days_apart <= days_c;
		result_q.order      <= order_s4;
		result_q.valid_a    <= ok_s4[0];
		result_q.valid_b    <= ok_s4[1];
		result_q.leap_a     <= leap_s4[0];
		result_q.leap_b     <= leap_s4[1];
	end

endmodule

`default_nettype wire

// File: rtl/core/datediff_checker.sv
// Port-level checks for date_day_difference, bound into each instance of it.
// Depends on datediff_pkg and date_day_difference_macros.svh.
`default_nettype none
`include "date_day_difference_macros.svh"

module datediff_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire logic                  done,
	input wire datediff_pkg::result_t result
);

	logic both_valid;
	logic same_date;
	logic days_zero;

	assign both_valid = result.valid_a && result.valid_b;
	assign same_date  = (result.order == datediff_pkg::ORD_EQUAL);
	assign days_zero  = (result.days_apart == 22'd0);

	`DD_ASSERT(a_never_busy, !busy, "busy raised on a pipe that never stalls")
	`DD_ASSERT_IMPL(a_latency, start && !busy, ##5 done, "transfer without result")
	`DD_ASSERT_IMPL(a_no_spurious, done, $past(start && !busy, 5), "result without transfer")
	`DD_ASSERT_IMPL(a_invalid_zero, done && !both_valid, days_zero, "invalid date, nonzero days")
	`DD_ASSERT_IMPL(a_equal_zero, done && same_date, days_zero, "equal dates, nonzero days")

endmodule

bind date_day_difference datediff_checker u_datediff_checker (.*);

`default_nettype wire
